[rtl/vnc_pkg.sv]
package vnc_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned LimitW = 31;
  localparam int unsigned SumW   = 64;
  localparam int unsigned ProdW  = 63;
  localparam int unsigned RootSteps = 32;
  localparam int unsigned DivSteps  = 31;
  localparam int unsigned Lanes     = 3;

  typedef struct packed {
    logic signed [WordW-1:0] x;
    logic signed [WordW-1:0] y;
    logic signed [WordW-1:0] z;
  } vec_t;

  typedef struct packed {
    vec_t                        vec;
    logic [Lanes-1:0][WordW-1:0] mag;
  } item_t;

  typedef struct packed {
    item_t           item;
    logic [SumW-1:0] rad;
    logic [34:0]     rem;
    logic [WordW-1:0] root;
  } root_stage_t;

  typedef struct packed {
    vec_t                         vec;
    logic                         clamp;
    logic [WordW-1:0]             norm;
    logic [Lanes-1:0][ProdW-1:0]  rem;
    logic [Lanes-1:0][LimitW-1:0] quo;
  } div_stage_t;

endpackage

[rtl/vnc_sqsum.sv]
module vnc_sqsum (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vnc_pkg::vec_t       vec,
  output logic                sum_valid,
  output vnc_pkg::item_t      sum_item,
  output logic [63:0]         sum
);
  import vnc_pkg::*;

  logic                       v1, v2;
  item_t                      it1, it2;
  logic [Lanes-1:0][SumW-1:0] sq;
  item_t                      it_in;

  function automatic logic [WordW-1:0] abs32(logic signed [WordW-1:0] a);
    return a[WordW-1] ? WordW'(-a) : WordW'(a);
  endfunction

  always_comb begin
    it_in.vec    = vec;
    it_in.mag[0] = abs32(vec.x);
    it_in.mag[1] = abs32(vec.y);
    it_in.mag[2] = abs32(vec.z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      sum_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      sum_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1 <= it_in;
      it2 <= it1;
      for (int i = 0; i < Lanes; i++) begin
        sq[i] <= SumW'(it1.mag[i]) * SumW'(it1.mag[i]);
      end
      sum_item <= it2;
      sum <= sq[0] + sq[1] + sq[2];
    end
  end

endmodule

[rtl/vnc_sqrt.sv]
module vnc_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic           in_valid,
  input  vnc_pkg::item_t in_item,
  input  logic [63:0]    rad,
  output logic           out_valid,
  output vnc_pkg::item_t out_item,
  output logic [31:0]    norm
);
  import vnc_pkg::*;

  logic        val [0:RootSteps];
  root_stage_t st  [0:RootSteps];

  assign val[0]       = in_valid;
  assign st[0].item   = in_item;
  assign st[0].rad    = rad;
  assign st[0].rem    = '0;
  assign st[0].root   = '0;

  for (genvar i = 0; i < RootSteps; i++) begin : g_step
    logic [34:0] remc;
    logic [34:0] trial;
    root_stage_t nxt;

    always_comb begin
      remc     = {st[i].rem[32:0], st[i].rad[SumW-1:SumW-2]};
      trial    = {1'b0, st[i].root, 2'b01};
      nxt.item = st[i].item;
      nxt.rad  = {st[i].rad[SumW-3:0], 2'b00};
      if (remc >= trial) begin
        nxt.rem  = remc - trial;
        nxt.root = {st[i].root[WordW-2:0], 1'b1};
      end else begin
        nxt.rem  = remc;
        nxt.root = {st[i].root[WordW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val[i+1] <= 1'b0;
      end else if (en) begin
        val[i+1] <= val[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[i+1] <= nxt;
      end
    end
  end

  assign out_valid = val[RootSteps];
  assign out_item  = st[RootSteps].item;
  assign norm      = st[RootSteps].root;

endmodule

[rtl/vnc_div.sv]
module vnc_div (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  vnc_pkg::div_stage_t in_stage,
  output logic                out_valid,
  output vnc_pkg::div_stage_t out_stage
);
  import vnc_pkg::*;

  logic       val [0:DivSteps];
  div_stage_t st  [0:DivSteps];

  assign val[0] = in_valid;
  assign st[0]  = in_stage;

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    localparam int unsigned Shift = DivSteps - 1 - k;
    logic [ProdW-1:0] dsh;
    div_stage_t       nxt;

    always_comb begin
      dsh = ProdW'(st[k].norm) << Shift;
      nxt = st[k];
      for (int l = 0; l < Lanes; l++) begin
        if (st[k].rem[l] >= dsh) begin
          nxt.rem[l] = st[k].rem[l] - dsh;
          nxt.quo[l] = {st[k].quo[l][LimitW-2:0], 1'b1};
        end else begin
          nxt.quo[l] = {st[k].quo[l][LimitW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        val[k+1] <= 1'b0;
      end else if (en) begin
        val[k+1] <= val[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1] <= nxt;
      end
    end
  end

  assign out_valid = val[DivSteps];
  assign out_stage = st[DivSteps];

endmodule

[rtl/vector_norm_clamp.sv]
// Channel   Direction  Handshake             Payload
// input     in         in_valid / in_stall   in_x, in_y, in_z
// output    out        out_valid / out_stall out_x, out_y, out_z, clamped
// config    in         cfg_write             cfg_data (norm_limit)
//
// One transaction per cycle while the pipeline is not stalled. The stages run in order: the sum of squares,
// the square root at one root bit per stage, the limit product,
// the divider at one quotient bit per stage, and the output register.
// rst is synchronous and clears all valid bits and norm_limit.
// A stalled output freezes the whole pipeline; in_stall follows it.
module vector_norm_clamp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [30:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_x,
  input  logic signed [31:0] in_y,
  input  logic signed [31:0] in_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               clamped
);
  import vnc_pkg::*;

  logic             en;
  logic [LimitW-1:0] norm_limit;
  vec_t             vec_in;
  logic             sq_valid, rt_valid, dv_in_valid, dv_valid;
  item_t            sq_item, rt_item;
  logic [SumW-1:0]  sum;
  logic [WordW-1:0] norm;
  div_stage_t       dv_in, dv_out;

  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;
  assign vec_in   = '{x: in_x, y: in_y, z: in_z};

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_limit <= '0;
    end else if (cfg_write) begin
      norm_limit <= cfg_data;
    end
  end

  vnc_sqsum u_sqsum (
    .clk, .rst, .en, .in_valid, .vec(vec_in),
    .sum_valid(sq_valid), .sum_item(sq_item), .sum
  );

  vnc_sqrt u_sqrt (
    .clk, .rst, .en, .in_valid(sq_valid), .in_item(sq_item), .rad(sum),
    .out_valid(rt_valid), .out_item(rt_item), .norm
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_in_valid <= 1'b0;
    end else if (en) begin
      dv_in_valid <= rt_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_in.vec   <= rt_item.vec;
      dv_in.clamp <= (norm_limit != '0) && (norm > WordW'(norm_limit));
      dv_in.norm  <= norm;
      dv_in.quo   <= '0;
      for (int l = 0; l < Lanes; l++) begin
        dv_in.rem[l] <= ProdW'(rt_item.mag[l]) * ProdW'(norm_limit);
      end
    end
  end

  vnc_div u_div (
    .clk, .rst, .en, .in_valid(dv_in_valid), .in_stage(dv_in),
    .out_valid(dv_valid), .out_stage(dv_out)
  );

  function automatic logic signed [WordW-1:0] scaled(
    logic signed [WordW-1:0] c, logic [LimitW-1:0] q);
    logic [WordW-1:0] qe;
    qe = WordW'(q);
    return c[WordW-1] ? WordW'(-qe) : qe;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      clamped <= dv_out.clamp;
      if (dv_out.clamp) begin
        out_x <= scaled(dv_out.vec.x, dv_out.quo[0]);
        out_y <= scaled(dv_out.vec.y, dv_out.quo[1]);
        out_z <= scaled(dv_out.vec.z, dv_out.quo[2]);
      end else begin
        out_x <= dv_out.vec.x;
        out_y <= dv_out.vec.y;
        out_z <= dv_out.vec.z;
      end
    end
  end

endmodule

[tb/tb_vector_norm_clamp.sv]
`timescale 1ns / 100ps

module tb_vector_norm_clamp;

  logic               clk;
  logic               rst;
  logic               cfg_write;
  logic [30:0]        cfg_data;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_z;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               clamped;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               clamped;
  } limited_vec_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               known;
    limited_vec_t       res;
  } stim_row_t;

  localparam int Latency = 68;
  localparam logic signed [31:0] MaxPos = 32'sh7fffffff;
  localparam logic signed [31:0] MinNeg = 32'sh80000000;
  localparam logic [30:0] MaxLimit = 31'h7fffffff;

  limited_vec_t limited_q[$];
  logic [30:0]  limit_reg;
  int           errors;
  logic         hold_off;

  vector_norm_clamp i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_write(cfg_write),
    .cfg_data (cfg_data),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_x     (in_x),
    .in_y     (in_y),
    .in_z     (in_z),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_x    (out_x),
    .out_y    (out_y),
    .out_z    (out_z),
    .clamped  (clamped)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = v;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic [31:0] scale_comp(logic signed [31:0] c, logic [30:0] lim,
                                             logic [63:0] norm);
    logic [63:0] mag;
    logic [63:0] q;
    mag = c[31] ? 64'(-{{32{c[31]}}, c}) : 64'({32'd0, c});
    q = (mag * 64'(lim)) / norm;
    return c[31] ? 32'(-q) : q[31:0];
  endfunction

  function automatic limited_vec_t limit_vec(logic signed [31:0] x, logic signed [31:0] y,
                                             logic signed [31:0] z, logic [30:0] lim);
    limited_vec_t r;
    logic [63:0] mx, my, mz, norm;
    mx = x[31] ? 64'(-{{32{1'b1}}, x}) : 64'(x);
    my = y[31] ? 64'(-{{32{1'b1}}, y}) : 64'(y);
    mz = z[31] ? 64'(-{{32{1'b1}}, z}) : 64'(z);
    norm = isqrt64(mx * mx + my * my + mz * mz);
    if (lim == 0 || norm <= 64'(lim)) begin
      r.x = x;
      r.y = y;
      r.z = z;
      r.clamped = 1'b0;
    end else begin
      r.x = scale_comp(x, lim, norm);
      r.y = scale_comp(y, lim, norm);
      r.z = scale_comp(z, lim, norm);
      r.clamped = 1'b1;
    end
    return r;
  endfunction

  task automatic send_vec(logic signed [31:0] x, logic signed [31:0] y,
                          logic signed [31:0] z, logic known, limited_vec_t typed);
    limited_vec_t p;
    p = limit_vec(x, y, z, limit_reg);
    if (known && p != typed) begin
      $error("typed row x=%h y=%h z=%h disagrees with prediction", x, y, z);
      errors++;
    end
    in_valid <= 1'b1;
    in_x <= x;
    in_y <= y;
    in_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    limited_q.push_back(p);
    if ($urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain_and_set(logic [30:0] lim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (limited_q.size() != 0) @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
    cfg_write <= 1'b1;
    cfg_data <= lim;
    limit_reg = lim;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic signed [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000);
      2: return 32'($signed($urandom_range(0, 32'h01ffffff)) - 32'sh01000000);
      default: return $urandom_range(0, 1) ? MaxPos - $urandom_range(0, 3)
                                           : MinNeg + $urandom_range(0, 3);
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 9) < 3);
    end
  end

  always @(posedge clk) begin
    limited_vec_t e;
    if (!rst && out_valid && !out_stall) begin
      if (limited_q.size() == 0) begin
        $error("result with nothing expected");
        errors++;
      end else begin
        e = limited_q.pop_front();
        if (out_x !== e.x) begin
          $error("out_x expected %h actual %h", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y expected %h actual %h", e.y, out_y);
          errors++;
        end
        if (out_z !== e.z) begin
          $error("out_z expected %h actual %h", e.z, out_z);
          errors++;
        end
        if (clamped !== e.clamped) begin
          $error("clamped expected %b actual %b", e.clamped, clamped);
          errors++;
        end
      end
    end
  end

  initial begin
    #20ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    hold_off = 1'b0;
    wait (rst === 1'b0);
    repeat (150) @(posedge clk);
    hold_off = 1'b1;
    repeat (200) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    stim_row_t rows[$];
    logic [30:0] limits[6];
    limited_vec_t none;
    int mode;
    errors = 0;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    in_x = '0;
    in_y = '0;
    in_z = '0;
    limit_reg = '0;
    none = '{32'sd0, 32'sd0, 32'sd0, 1'b0};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
      '{MaxPos, MaxPos, MaxPos, 1'b1, '{MaxPos, MaxPos, MaxPos, 1'b0}},
      '{MinNeg, MinNeg, MinNeg, 1'b1, '{MinNeg, MinNeg, MinNeg, 1'b0}},
      '{MinNeg, MaxPos, 32'sd0, 1'b1, '{MinNeg, MaxPos, 32'sd0, 1'b0}},
      '{32'sd1, -32'sd1, 32'sd65536, 1'b0, none}
    };
    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);

    // limit 1.0: norm equal to limit passes, larger is scaled
    drain_and_set(31'h00010000);
    rows = '{
      '{32'sd0, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 1'b0}},
      '{32'sh00010000, 32'sd0, 32'sd0, 1'b1, '{32'sh00010000, 32'sd0, 32'sd0, 1'b0}},
      '{32'sh00010001, 32'sd0, 32'sd0, 1'b1, '{32'sh00010000, 32'sd0, 32'sd0, 1'b1}},
      '{32'sd0, MinNeg, 32'sd0, 1'b1, '{32'sd0, -32'sh00010000, 32'sd0, 1'b1}},
      '{32'sd0, 32'sd0, MaxPos, 1'b0, none},
      '{32'sh00030000, -32'sh00040000, 32'sd0, 1'b1,
        '{32'sh00009999, -32'sh0000cccc, 32'sd0, 1'b1}},
      '{MinNeg, MinNeg, MaxPos, 1'b0, none}
    };
    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);

    drain_and_set(31'd1);
    rows = '{
      '{32'sd1, 32'sd0, 32'sd0, 1'b1, '{32'sd1, 32'sd0, 32'sd0, 1'b0}},
      '{MaxPos, MinNeg, MaxPos, 1'b0, none},
      '{32'sd2, -32'sd2, 32'sd2, 1'b0, none}
    };
    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);

    drain_and_set(MaxLimit);
    rows = '{
      '{MaxPos, 32'sd0, 32'sd0, 1'b1, '{MaxPos, 32'sd0, 32'sd0, 1'b0}},
      '{MinNeg, 32'sd0, 32'sd0, 1'b1, '{-MaxPos, 32'sd0, 32'sd0, 1'b1}},
      '{MinNeg, MinNeg, MinNeg, 1'b0, none},
      '{MaxPos, MaxPos, 32'sd0, 1'b0, none}
    };
    foreach (rows[i]) send_vec(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);

    limits = '{31'h00010000, 31'd0, 31'h00018000, MaxLimit, 31'd1, 31'h00000000};
    limits[5] = 31'($urandom);
    foreach (limits[p]) begin
      drain_and_set(limits[p]);
      repeat (90) begin
        mode = $urandom_range(0, 4);
        if (mode == 4) mode = $urandom_range(0, 3);
        send_vec(rand_comp(mode), rand_comp(mode), rand_comp($urandom_range(0, 3)),
                 1'b0, none);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (limited_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
rtl/vnc_pkg.sv
rtl/vnc_sqsum.sv
rtl/vnc_sqrt.sv
rtl/vnc_div.sv
rtl/vector_norm_clamp.sv
tb/tb_vector_norm_clamp.sv
